[hw/rtl/clamped_linear_interpolation_table_defines.svh]
// assertion macros shared by the checker
`ifndef CLAMPED_LINEAR_INTERPOLATION_TABLE_DEFINES_SVH
`define CLAMPED_LINEAR_INTERPOLATION_TABLE_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define CLIT_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("clit check failed");

// next-cycle implication, held off while reset is low
`define CLIT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("clit check failed");

`endif

[hw/rtl/clit_pkg.sv]
// shared constants, codes and types of the interpolation table
package clit_pkg;

    localparam int ENTRIES  = 64;
    localparam int TABLES   = 4;
    localparam int NUM_REGS = 4;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int TSEL_W   = $clog2(TABLES);
    localparam int ADDR_W   = IDX_W + TSEL_W;
    localparam int DEPTH    = TABLES * ENTRIES;
    localparam int CNT_W    = 7;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 4;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] REG_ENT_A = 2'd0;
    localparam logic [1:0] REG_ENT_B = 2'd1;
    localparam logic [1:0] REG_ENT_C = 2'd2;
    localparam logic [1:0] REG_ENT_D = 2'd3;

    typedef enum logic [2:0] {
        ST_LOADED = 3'd0,
        ST_EXACT  = 3'd1,
        ST_INTERP = 3'd2,
        ST_LOW    = 3'd3,
        ST_HIGH   = 3'd4,
        ST_EMPTY  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_VAL0,
        S_VAL1,
        S_MATH,
        S_DONE
    } ctl_state_t;

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV
    } arith_state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] lv;
        logic signed [DATA_W-1:0] rv;
        logic signed [DATA_W-1:0] lk;
        logic signed [DATA_W-1:0] rk;
        logic signed [DATA_W-1:0] q;
    } arith_req_t;

endpackage

[hw/rtl/clit_arith.sv]
// iterative interpolation unit: shift-add multiply then restoring divide
module clit_arith
    import clit_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  arith_req_t               req,
    output logic                     done,
    output logic signed [DATA_W-1:0] result
);

    localparam int W  = DATA_W + 1;
    localparam int PW = 2 * W;

    arith_state_t     ast_reg, ast_next;
    logic [6:0]       cnt_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [DATA_W-1:0] lv_reg;
    logic [W-1:0]     mag_reg;
    logic [W-1:0]     dq_reg;
    logic [W-1:0]     den_reg;
    logic [PW-1:0]    acc_reg;
    logic [W:0]       rem_reg;

    logic signed [W-1:0] dv;
    logic [W-1:0]     dq_in;
    logic [W-1:0]     den_in;
    logic [W:0]       trial;
    logic             ge;
    logic             mul_last;
    logic             div_last;

    always_comb
    begin
        dv     = {req.rv[DATA_W-1], req.rv} - {req.lv[DATA_W-1], req.lv};
        dq_in  = {req.q[DATA_W-1], req.q} - {req.lk[DATA_W-1], req.lk};
        den_in = {req.rk[DATA_W-1], req.rk} - {req.lk[DATA_W-1], req.lk};
    end

    // divide trial step and last-step decode
    always_comb
    begin
        trial    = {rem_reg[W-1:0], acc_reg[PW-1]};
        ge       = (trial >= {1'b0, den_reg});
        mul_last = (ast_reg == A_MUL) && (cnt_reg == 7'(W - 1));
        div_last = (ast_reg == A_DIV) && (cnt_reg == 7'(PW - 1));
    end

    always_comb
    begin
        ast_next = ast_reg;
        case (ast_reg)
            A_IDLE:
            begin
                if (start && (den_in != '0))
                begin
                    ast_next = A_MUL;
                end
            end
            A_MUL:
            begin
                if (mul_last)
                begin
                    ast_next = A_DIV;
                end
            end
            A_DIV:
            begin
                if (div_last)
                begin
                    ast_next = A_IDLE;
                end
            end
            default:
            begin
                ast_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ast_reg  <= A_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ast_reg  <= ast_next;
            done_reg <= (start && (den_in == '0)) || div_last;
            if (ast_reg != ast_next || ast_reg == A_IDLE)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ast_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    lv_reg  <= req.lv;
                    neg_reg <= dv[W-1];
                    mag_reg <= dv[W-1] ? W'(-dv) : W'(dv);
                    dq_reg  <= dq_in;
                    den_reg <= den_in;
                    acc_reg <= '0;
                    rem_reg <= '0;
                end
            end
            A_MUL:
            begin
                acc_reg <= {acc_reg[PW-2:0], 1'b0}
                         + (dq_reg[W-1] ? {{W{1'b0}}, mag_reg} : {PW{1'b0}});
                dq_reg  <= {dq_reg[W-2:0], 1'b0};
            end
            A_DIV:
            begin
                rem_reg <= ge ? (trial - {1'b0, den_reg}) : trial;
                acc_reg <= {acc_reg[PW-2:0], ge};
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = neg_reg ? (lv_reg - acc_reg[DATA_W-1:0])
                            : (lv_reg + acc_reg[DATA_W-1:0]);

endmodule

[hw/rtl/clamped_linear_interpolation_table.sv]
// top level of the clamped piecewise-linear interpolation table
// load beat: S_DONE registers the result once the output register is free, then S_IDLE
// takes the next beat; lookup beat: a linear scan of the key memory (one read a cycle)
// over the breakpoints in use, S_DECIDE, S_VAL0, and when interpolating S_VAL1 and the
// multiply and divide of the arithmetic unit, then S_DONE; empty tables answer like loads
// reset clears control and entry counts; breakpoint memories are undefined until loaded
module clamped_linear_interpolation_table
    import clit_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // item channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  logic [TSEL_W-1:0]        table_select,
    input  logic [IDX_W-1:0]         entry_index,
    input  logic signed [DATA_W-1:0] entry_key,
    input  logic signed [DATA_W-1:0] entry_value,
    input  logic signed [DATA_W-1:0] query_key,
    // result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] result_value,
    output logic [2:0]               status,
    // register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    // breakpoint memories, indexed by {table, position}
    logic [DATA_W-1:0] key_mem [DEPTH];
    logic [DATA_W-1:0] val_mem [DEPTH];
    logic signed [DATA_W-1:0] key_rdata_reg;
    logic signed [DATA_W-1:0] val_rdata_reg;

    // entry counts
    logic [CNT_W-1:0] ent_a_reg, ent_b_reg, ent_c_reg, ent_d_reg;

    ctl_state_t state_reg, state_next;

    // item context
    logic [TSEL_W-1:0]        tsel_reg;
    logic signed [DATA_W-1:0] q_reg;
    logic [CNT_W-1:0]         cnt_reg;

    // scan pipeline: read issued one cycle, compared the next
    logic [CNT_W-1:0] issue_reg;
    logic             dvld_reg;
    logic [IDX_W-1:0] didx_reg;

    // scan findings
    logic                     exact_f_reg;
    logic [IDX_W-1:0]         exact_idx_reg;
    logic signed [DATA_W-1:0] k0_reg, klast_reg, prev_reg;
    logic                     gt_f_reg;
    logic [IDX_W-1:0]         gt_idx_reg;
    logic signed [DATA_W-1:0] lk_reg, rk_reg, lv_reg;

    // pending result and output register
    logic signed [DATA_W-1:0] res_reg;
    status_t                  stat_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    status_t                  out_status_reg;

    // control decode
    logic              accept;
    logic              cfg_wr;
    logic [CNT_W-1:0]  sel_ent;
    logic [CNT_W-1:0]  n_clamped;
    logic              key_re, val_re;
    logic [IDX_W-1:0]  key_ridx, val_ridx;
    logic              scan_last;
    logic              out_load;
    status_t           decide_stat;
    logic [IDX_W-1:0]  decide_idx;
    logic              arith_start;
    logic              arith_done;
    logic signed [DATA_W-1:0] arith_result;
    arith_req_t        arith_req;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // entry count of the addressed table, clamped to the table depth
    always_comb
    begin
        case (table_select)
            REG_ENT_A: sel_ent = ent_a_reg;
            REG_ENT_B: sel_ent = ent_b_reg;
            REG_ENT_C: sel_ent = ent_c_reg;
            REG_ENT_D: sel_ent = ent_d_reg;
            default:   sel_ent = '0;
        endcase
        n_clamped = (sel_ent > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : sel_ent;
    end

    // register read-back
    always_comb
    begin
        case (paddr[3:2])
            REG_ENT_A: prdata = DATA_W'(ent_a_reg);
            REG_ENT_B: prdata = DATA_W'(ent_b_reg);
            REG_ENT_C: prdata = DATA_W'(ent_c_reg);
            REG_ENT_D: prdata = DATA_W'(ent_d_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_a_reg <= '0;
            ent_b_reg <= '0;
            ent_c_reg <= '0;
            ent_d_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ENT_A: ent_a_reg <= pwdata[CNT_W-1:0];
                REG_ENT_B: ent_b_reg <= pwdata[CNT_W-1:0];
                REG_ENT_C: ent_c_reg <= pwdata[CNT_W-1:0];
                REG_ENT_D: ent_d_reg <= pwdata[CNT_W-1:0];
                default:   ent_a_reg <= ent_a_reg;
            endcase
        end
    end

    // the last scanned key has arrived
    assign scan_last = dvld_reg && ({1'b0, didx_reg} == (cnt_reg - CNT_W'(1)));

    // classify the query once the scan is done: exact, below, above or between
    always_comb
    begin
        if (exact_f_reg)
        begin
            decide_stat = ST_EXACT;
            decide_idx  = exact_idx_reg;
        end
        else if (q_reg < k0_reg)
        begin
            decide_stat = ST_LOW;
            decide_idx  = '0;
        end
        else if (q_reg > klast_reg)
        begin
            decide_stat = ST_HIGH;
            decide_idx  = IDX_W'(cnt_reg - CNT_W'(1));
        end
        else
        begin
            decide_stat = ST_INTERP;
            decide_idx  = gt_idx_reg - IDX_W'(1);
        end
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_LOOKUP && n_clamped != '0)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_VAL0;
            end
            S_VAL0:
            begin
                state_next = (stat_reg == ST_INTERP) ? S_VAL1 : S_DONE;
            end
            S_VAL1:
            begin
                state_next = S_MATH;
            end
            S_MATH:
            begin
                if (arith_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory read ports and unit start
    always_comb
    begin
        key_re      = 1'b0;
        key_ridx    = issue_reg[IDX_W-1:0];
        val_re      = 1'b0;
        val_ridx    = decide_idx;
        arith_start = 1'b0;
        case (state_reg)
            S_SCAN:
            begin
                key_re = (issue_reg < cnt_reg);
            end
            S_DECIDE:
            begin
                val_re = 1'b1;
            end
            S_VAL0:
            begin
                val_re   = (stat_reg == ST_INTERP);
                val_ridx = gt_idx_reg;
            end
            S_VAL1:
            begin
                arith_start = 1'b1;
            end
            default:
            begin
                key_re = 1'b0;
            end
        endcase
    end

    // memories: one write and one registered read per cycle each
    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_LOAD)
        begin
            key_mem[{table_select, entry_index}] <= entry_key;
            val_mem[{table_select, entry_index}] <= entry_value;
        end
        if (key_re)
        begin
            key_rdata_reg <= key_mem[{tsel_reg, key_ridx}];
        end
        if (val_re)
        begin
            val_rdata_reg <= val_mem[{tsel_reg, val_ridx}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dvld_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dvld_reg  <= key_re;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        didx_reg <= issue_reg[IDX_W-1:0];
        if (key_re)
        begin
            issue_reg <= issue_reg + CNT_W'(1);
        end
        case (state_reg)
            S_IDLE:
            begin
                tsel_reg    <= table_select;
                q_reg       <= query_key;
                cnt_reg     <= n_clamped;
                issue_reg   <= '0;
                exact_f_reg <= 1'b0;
                gt_f_reg    <= 1'b0;
                res_reg     <= '0;
                stat_reg    <= (operation == OP_LOOKUP) ? ST_EMPTY : ST_LOADED;
            end
            S_SCAN:
            begin
                if (dvld_reg)
                begin
                    if (didx_reg == '0)
                    begin
                        k0_reg <= key_rdata_reg;
                    end
                    klast_reg <= key_rdata_reg;
                    prev_reg  <= key_rdata_reg;
                    // lowest matching position wins
                    if (!exact_f_reg && key_rdata_reg == q_reg)
                    begin
                        exact_f_reg   <= 1'b1;
                        exact_idx_reg <= didx_reg;
                    end
                    // first key above the query from position one on
                    if (!gt_f_reg && didx_reg != '0 && key_rdata_reg > q_reg)
                    begin
                        gt_f_reg   <= 1'b1;
                        gt_idx_reg <= didx_reg;
                        rk_reg     <= key_rdata_reg;
                        lk_reg     <= prev_reg;
                    end
                end
            end
            S_DECIDE:
            begin
                stat_reg <= decide_stat;
            end
            S_VAL0:
            begin
                lv_reg  <= val_rdata_reg;
                res_reg <= val_rdata_reg;
            end
            S_MATH:
            begin
                if (arith_done)
                begin
                    res_reg <= arith_result;
                end
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
        if (out_load)
        begin
            out_value_reg  <= res_reg;
            out_status_reg <= stat_reg;
        end
    end

    always_comb
    begin
        arith_req.lv = lv_reg;
        arith_req.rv = val_rdata_reg;
        arith_req.lk = lk_reg;
        arith_req.rk = rk_reg;
        arith_req.q  = q_reg;
    end

    clit_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (arith_start),
        .req    (arith_req),
        .done   (arith_done),
        .result (arith_result)
    );

    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign status       = out_status_reg;

endmodule

[hw/rtl/clit_checker.sv]
// port-level checker for the interpolation table, bound to the top level
`include "clamped_linear_interpolation_table_defines.svh"

module clit_checker
    import clit_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     operation,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] result_value,
    input logic [2:0]               status
);

    // one item in flight: ready drops after each accepted beat
    `CLIT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
    // load and empty-table answers carry a zero value
    `CLIT_ASSERT_NOW(a_zero_value, clk, rst_n, out_valid && (status == ST_LOADED || status == ST_EMPTY), result_value == '0)
    // a load beat accepted while the output is empty answers with the loaded status after S_DONE
    `CLIT_ASSERT_NEXT(a_load_fast, clk, rst_n, in_valid && in_ready && operation == OP_LOAD && !out_valid, ##1 (out_valid && status == ST_LOADED))
    // stalled result beat holds
    `CLIT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(status))

endmodule

bind clamped_linear_interpolation_table clit_checker u_clit_checker (.*);

[dv/clamped_linear_interpolation_table_test.sv]
// testbench for the clamped linear interpolation table: directed and random beats checked against a predictor
module clamped_linear_interpolation_table_test;
    import clit_pkg::*;

    typedef struct {
        logic                     operation;
        logic [TSEL_W-1:0]        table_select;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] entry_key;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] query_key;
    } beat_t;

    typedef struct {
        logic [DATA_W-1:0] value;
        status_t           status;
    } answer_t;

    // dut ports, inputs driven to known values from time zero
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     operation = OP_LOAD;
    logic [TSEL_W-1:0]        table_select = '0;
    logic [IDX_W-1:0]         entry_index = '0;
    logic signed [DATA_W-1:0] entry_key = '0;
    logic signed [DATA_W-1:0] entry_value = '0;
    logic signed [DATA_W-1:0] query_key = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] result_value;
    logic [2:0]               status;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    clamped_linear_interpolation_table u_top (.*);

    // beats waiting for the driver and answers waiting for the dut
    beat_t   beat_queue[$];
    answer_t answer_queue[$];
    int      mismatches = 0;
    int      cycle_count = 0;

    // predictor copy of the breakpoint stores and entry counts
    logic [DATA_W-1:0] pred_key[DEPTH];
    logic [DATA_W-1:0] pred_value[DEPTH];
    logic [CNT_W-1:0]  pred_count[NUM_REGS];

    // generator shadow: what has been loaded, used to pick legal lookups and queries
    bit                gen_written[DEPTH];
    logic [DATA_W-1:0] gen_key[DEPTH];
    int                gen_count[NUM_REGS];
    int                total_beats = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("** clamped_linear_interpolation_table: FAILED **");
        $finish;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // idle with a chance of about 7 in 100 on each call, except for a stretch with no breaks in the middle of the run
    function automatic bit take_break();
        if (cycle_count >= 60_000 && cycle_count < 120_000)
            return 1'b0;
        return $urandom_range(99) < 7;
    endfunction

    // driver: new beat only when the slot is empty or the current beat just went in
    always @(posedge clk)
    begin
        if (!in_valid || in_ready)
        begin
            if (beat_queue.size() != 0 && !take_break())
            begin
                in_valid     <= 1'b1;
                operation    <= beat_queue[0].operation;
                table_select <= beat_queue[0].table_select;
                entry_index  <= beat_queue[0].entry_index;
                entry_key    <= beat_queue[0].entry_key;
                entry_value  <= beat_queue[0].entry_value;
                query_key    <= beat_queue[0].query_key;
                void'(beat_queue.pop_front());
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
        out_ready <= !take_break();

    // lookup predictor: empty table first, then exact match, then clamps, then interpolation
    function automatic answer_t predict_lookup(int t, logic signed [DATA_W-1:0] q);
        answer_t         a;
        int              n;
        int              base;
        int              right;
        longint          lk, lv, rk, rv, dv;
        bit [63:0]       dq, den, mag, quot;
        a.value = '0;
        n = (pred_count[t] > ENTRIES) ? ENTRIES : pred_count[t];
        if (n == 0)
        begin
            a.status = ST_EMPTY;
            return a;
        end
        base = t * ENTRIES;
        for (int i = 0; i < n; i++)
        begin
            if ($signed(pred_key[base + i]) == q)
            begin
                a.status = ST_EXACT;
                a.value  = pred_value[base + i];
                return a;
            end
        end
        if (q < $signed(pred_key[base]))
        begin
            a.status = ST_LOW;
            a.value  = pred_value[base];
            return a;
        end
        if (q > $signed(pred_key[base + n - 1]))
        begin
            a.status = ST_HIGH;
            a.value  = pred_value[base + n - 1];
            return a;
        end
        // lowest position past zero whose key is above the query
        right = n - 1;
        for (int j = 1; j < n; j++)
        begin
            if ($signed(pred_key[base + j]) > q)
            begin
                right = j;
                break;
            end
        end
        lk  = $signed(pred_key[base + right - 1]);
        lv  = $signed(pred_value[base + right - 1]);
        rk  = $signed(pred_key[base + right]);
        rv  = $signed(pred_value[base + right]);
        dv  = rv - lv;
        dq  = longint'(q) - lk;
        den = rk - lk;
        a.status = ST_INTERP;
        if (den == 0)
        begin
            a.value = lv[31:0];
            return a;
        end
        mag  = (dv < 0) ? -dv : dv;
        quot = (mag * dq) / den;
        a.value = (dv < 0) ? (lv[31:0] - quot[31:0]) : (lv[31:0] + quot[31:0]);
        return a;
    endfunction

    // monitor: predict on input beats, check on output beats
    always @(posedge clk)
    begin
        answer_t a;
        int      addr;
        if (rst_n && in_valid && in_ready)
        begin
            a.value  = '0;
            a.status = ST_LOADED;
            if (operation == OP_LOAD)
            begin
                addr = table_select * ENTRIES + entry_index;
                pred_key[addr]   = entry_key;
                pred_value[addr] = entry_value;
            end
            else
            begin
                a = predict_lookup(table_select, query_key);
            end
            answer_queue.push_back(a);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (answer_queue.size() == 0)
            begin
                $error("result beat with nothing expected: value %h status %0d",
                       result_value, status);
                mismatches++;
            end
            else
            begin
                a = answer_queue.pop_front();
                if (result_value !== a.value)
                begin
                    $error("result_value: expected %h actual %h", a.value, result_value);
                    mismatches++;
                end
                if (status !== a.status)
                begin
                    $error("status: expected %0d actual %0d", a.status, status);
                    mismatches++;
                end
            end
        end
    end

    // register write: setup then access, lands at the access edge
    task automatic write_count(logic [1:0] reg_index, int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(reg_index * 4);
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pred_count[reg_index] = value[CNT_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold the sender until every answer is back, then let the last lookup drain
    task automatic wait_idle();
        do
            @(posedge clk);
        while (beat_queue.size() != 0 || in_valid || answer_queue.size() != 0);
        repeat (250) @(posedge clk);
    endtask

    task automatic push_load(int t, int i, logic [31:0] k, logic [31:0] v);
        beat_t b;
        b.operation    = OP_LOAD;
        b.table_select = TSEL_W'(t);
        b.entry_index  = IDX_W'(i);
        b.entry_key    = k;
        b.entry_value  = v;
        b.query_key    = $urandom;
        beat_queue.push_back(b);
        gen_written[t * ENTRIES + i] = 1'b1;
        gen_key[t * ENTRIES + i]     = k;
        total_beats++;
    endtask

    task automatic push_lookup(int t, logic [31:0] q);
        beat_t b;
        b.operation    = OP_LOOKUP;
        b.table_select = TSEL_W'(t);
        b.entry_index  = IDX_W'($urandom);
        b.entry_key    = $urandom;
        b.entry_value  = $urandom;
        b.query_key    = q;
        beat_queue.push_back(b);
        total_beats++;
    endtask

    // table of ascending keys, now and then with a duplicate or a swapped pair
    task automatic load_table(int t, int n);
        int keys[$];
        int span;
        int tmp;
        int p;
        span = $urandom_range(3);
        for (int i = 0; i < n; i++)
        begin
            case (span)
                0: keys.push_back($urandom_range(2000) - 1000);
                1: keys.push_back($urandom_range(1 << 20) - (1 << 19));
                default: keys.push_back($urandom);
            endcase
        end
        keys.sort();
        if (n > 2 && $urandom_range(9) == 0)
        begin
            p = $urandom_range(n - 2);
            keys[p + 1] = keys[p];
        end
        if (n > 2 && $urandom_range(9) == 0)
        begin
            p = $urandom_range(n - 2);
            tmp = keys[p];
            keys[p] = keys[p + 1];
            keys[p + 1] = tmp;
        end
        for (int i = 0; i < n; i++)
            push_load(t, i, keys[i], ($urandom_range(3) == 0)
                      ? $urandom_range(2000) - 1000 : $urandom);
    endtask

    function automatic logic [31:0] pick_query(int t);
        int n;
        int i;
        n = (gen_count[t] > ENTRIES) ? ENTRIES : gen_count[t];
        i = (n > 0) ? t * ENTRIES + $urandom_range(n - 1) : 0;
        case ($urandom_range(7))
            0: return gen_key[i];
            1: return gen_key[i] + 1;
            2: return gen_key[i] - 1;
            3: return 32'h8000_0000;
            4: return 32'h7fff_ffff;
            5: return $urandom;
            default: return gen_key[i] + $urandom_range(400) - 200;
        endcase
    endfunction

    function automatic bit table_loaded(int t);
        int n;
        n = (gen_count[t] > ENTRIES) ? ENTRIES : gen_count[t];
        for (int i = 0; i < n; i++)
            if (!gen_written[t * ENTRIES + i])
                return 1'b0;
        return 1'b1;
    endfunction

    initial
    begin
        int  n;
        int  t;
        int  sizes[4];
        for (int r = 0; r < NUM_REGS; r++)
        begin
            pred_count[r] = '0;
            gen_count[r]  = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty tables, then a small table with extreme values
        for (int k = 0; k < 4; k++)
            push_lookup(k, 32'h8000_0000 + k);
        push_load(0, 0, -1000, 32'h8000_0000);
        push_load(0, 1, 0, 32'h7fff_ffff);
        push_load(0, 2, 1000, 32'hffff_ffff);
        push_load(0, 3, 3000, 5);
        wait_idle();
        write_count(REG_ENT_A, 4);
        gen_count[0] = 4;
        push_lookup(0, -1000);
        push_lookup(0, 3000);
        push_lookup(0, 32'h8000_0000);
        push_lookup(0, 32'h7fff_ffff);
        push_lookup(0, -500);
        push_lookup(0, 500);
        push_lookup(0, 1999);
        push_lookup(1, 0);

        // random phases: new counts while idle, reload tables, then lookups mixed with stray loads
        while (total_beats < 1800)
        begin
            wait_idle();
            for (int r = 0; r < NUM_REGS; r++)
            begin
                case ($urandom_range(6))
                    0: n = 0;
                    1: n = 1;
                    2: n = 2;
                    3: n = ENTRIES;
                    4: n = 127;
                    default: n = $urandom_range(3, 24);
                endcase
                sizes[r] = n;
                gen_count[r] = n;
            end
            write_count(REG_ENT_A, sizes[0]);
            write_count(REG_ENT_B, sizes[1]);
            write_count(REG_ENT_C, sizes[2]);
            write_count(REG_ENT_D, sizes[3]);
            for (int r = 0; r < NUM_REGS; r++)
            begin
                n = (sizes[r] > ENTRIES) ? ENTRIES : sizes[r];
                if (n > 0 && (!table_loaded(r) || $urandom_range(1) == 0))
                    load_table(r, n);
            end
            for (int k = 0; k < 40; k++)
            begin
                t = $urandom_range(3);
                if ($urandom_range(9) == 0)
                    push_load(t, $urandom_range(ENTRIES - 1), $urandom, $urandom);
                else if (table_loaded(t))
                    push_lookup(t, pick_query(t));
            end
        end

        wait_idle();
        if (mismatches == 0 && answer_queue.size() == 0)
            $display("** clamped_linear_interpolation_table: PASSED **");
        else
            $display("** clamped_linear_interpolation_table: FAILED **");
        $finish;
    end

endmodule

[clamped_linear_interpolation_table.f]
+incdir+hw/rtl
hw/rtl/clit_pkg.sv
hw/rtl/clit_arith.sv
hw/rtl/clamped_linear_interpolation_table.sv
hw/rtl/clit_checker.sv
dv/clamped_linear_interpolation_table_test.sv
